[sv/chassis_wheel_speed_mixer_unit_defines.svh]
// Assertion macros for the wheel speed mixer checker.
// Expects clk and arst_n in the scope of use.
`ifndef CHASSIS_WHEEL_SPEED_MIXER_UNIT_DEFINES_SVH
`define CHASSIS_WHEEL_SPEED_MIXER_UNIT_DEFINES_SVH

// same-cycle implication
`define CWSM_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("cwsm check failed");

// next-cycle implication
`define CWSM_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("cwsm check failed");

`endif

[sv/cwsm_pkg.sv]
// Shared constants, drive codes and the CORDIC angle table for the
// wheel speed mixer. No dependencies.
package cwsm_pkg;

	localparam int SPEED_WIDTH_DEF = 16;
	localparam int Q15_ONE         = 32768;
	localparam int SQRT3_HALF_Q15  = 28378;
	localparam int INV_GAIN_Q15    = 19899;
	localparam int CORDIC_STEPS    = 14;
	localparam int GUARD_SHIFT     = 8;
	localparam int ITER_STAGES     = 8;
	localparam int ZW              = 17;
	localparam int RAD_W           = 32;
	localparam int REM_W           = 20;
	localparam int ROOT_W          = 16;
	localparam int FRAC_W          = 16;

	typedef enum logic [2:0] {
		DRIVE_DIFF    = 3'd0,
		DRIVE_OMNI3   = 3'd1,
		DRIVE_SKID    = 3'd2,
		DRIVE_MECANUM = 3'd3,
		DRIVE_OFFSET  = 3'd4
	} drive_kind_t;

	localparam logic [1:0] REG_DRIVE_KIND = 2'd0;
	localparam logic [1:0] REG_HEADLESS   = 2'd1;
	localparam logic [1:0] REG_WIDTH_FR   = 2'd2;
	localparam logic [1:0] REG_LENGTH_FR  = 2'd3;

	// arctangent of 2^-i in 1/65536 turns
	function automatic logic signed [ZW-1:0] atan_turn(input int i);
		logic signed [ZW-1:0] r;
		begin
			case (i)
				0: r = 17'sd8192;
				1: r = 17'sd4836;
				2: r = 17'sd2555;
				3: r = 17'sd1297;
				4: r = 17'sd651;
				5: r = 17'sd326;
				6: r = 17'sd163;
				7: r = 17'sd81;
				8: r = 17'sd41;
				9: r = 17'sd20;
				10: r = 17'sd10;
				11: r = 17'sd5;
				12: r = 17'sd3;
				13: r = 17'sd1;
				default: r = 17'sd0;
			endcase
			return r;
		end
	endfunction

endpackage

[sv/chassis_wheel_speed_mixer_unit.sv]
// Wheel speed mixer: a pipeline from input transaction to result. Throughput
// one command per cycle; the iteration stages (two root digits each, and two
// CORDIC steps in all but the last) set the pipeline depth. The whole
// pipeline holds while the output register waits. Reset clears valid bits
// and sets configuration registers to defaults. Uses cwsm_pkg, cwsm_iter_stage.
module chassis_wheel_speed_mixer_unit #(
	parameter int SPEED_WIDTH = cwsm_pkg::SPEED_WIDTH_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic s_tvalid,
	output logic s_tready,
	// forward_speed, side_speed, turn_speed, heading_angle, zero pad
	input  logic [((3*SPEED_WIDTH+16+7)/8)*8-1:0] s_tdata,
	output logic m_tvalid,
	input  logic m_tready,
	// wheel_zero, wheel_one, wheel_two, wheel_three, zero pad
	output logic [((4*(SPEED_WIDTH+2)+7)/8)*8-1:0] m_tdata,
	// command_valid
	output logic [0:0] m_tuser,
	input  logic psel,
	input  logic penable,
	input  logic pwrite,
	input  logic [3:0] paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready
);
	localparam int SW = SPEED_WIDTH;
	localparam int XW = SW + 10;
	localparam int VW = SW + 2;
	localparam int OUT_DW = ((4*VW+7)/8)*8;
	localparam int PX_W = XW + 16;
	localparam int YP_W = SW + 18;
	localparam int OM_W = VW + 16;
	localparam int MW = SW + 20;
	localparam int NS = cwsm_pkg::ITER_STAGES;
	localparam int ZW = cwsm_pkg::ZW;
	localparam int FW = cwsm_pkg::FRAC_W;
	localparam logic signed [PX_W-1:0] HALF_PX = PX_W'(1 << 22);
	localparam logic signed [YP_W-1:0] HALF_YP = YP_W'(1 << 14);
	localparam logic signed [MW-1:0] HALF_M = MW'(1 << 14);
	localparam logic signed [MW-1:0] SAT_HI = MW'((64'sd1 <<< (SW+1)) - 64'sd1);
	localparam logic signed [MW-1:0] SAT_LO = -SAT_HI - MW'(1);

	// configuration
	logic [2:0] drive_kind_q;
	logic headless_q;
	logic [FW-1:0] wfrac_q, lfrac_q;
	logic cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			drive_kind_q <= cwsm_pkg::DRIVE_DIFF;
			headless_q <= 1'b0;
			wfrac_q <= FW'(16384);
			lfrac_q <= FW'(16384);
		end else if (cfg_wr) begin
			case (paddr[3:2])
				cwsm_pkg::REG_DRIVE_KIND: drive_kind_q <= pwdata[2:0];
				cwsm_pkg::REG_HEADLESS:   headless_q <= pwdata[0];
				cwsm_pkg::REG_WIDTH_FR:   wfrac_q <= pwdata[FW-1:0];
				cwsm_pkg::REG_LENGTH_FR:  lfrac_q <= pwdata[FW-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[3:2])
			cwsm_pkg::REG_DRIVE_KIND: prdata = {29'd0, drive_kind_q};
			cwsm_pkg::REG_HEADLESS:   prdata = {31'd0, headless_q};
			cwsm_pkg::REG_WIDTH_FR:   prdata = {16'd0, wfrac_q};
			cwsm_pkg::REG_LENGTH_FR:  prdata = {16'd0, lfrac_q};
			default:                  prdata = 32'd0;
		endcase
	end

	logic rot_en;
	assign rot_en = headless_q && (drive_kind_q == cwsm_pkg::DRIVE_OMNI3 ||
		drive_kind_q == cwsm_pkg::DRIVE_MECANUM);

	// global pipeline advance
	logic en;
	assign en = !m_tvalid || m_tready;
	assign s_tready = en;

	// stage 1: quadrant fold, guard scaling, fraction products
	logic signed [SW-1:0] vx_in, vy_in, w_in;
	logic [15:0] hd_in, rz;
	logic signed [ZW-1:0] z0;
	logic fold;
	logic signed [XW-1:0] x0, y0;
	logic [FW-1:0] cw, cl;

	assign vx_in = s_tdata[SW-1:0];
	assign vy_in = s_tdata[2*SW-1:SW];
	assign w_in = s_tdata[3*SW-1:2*SW];
	assign hd_in = s_tdata[3*SW +: 16];
	assign cw = FW'(17'd32768 - {1'b0, wfrac_q});
	assign cl = FW'(17'd32768 - {1'b0, lfrac_q});

	always_comb begin
		logic signed [ZW-1:0] zr;
		rz = 16'd0 - hd_in;
		zr = ZW'($signed(rz));
		fold = (zr > ZW'(16384)) || (zr < -ZW'(16384));
		if (zr > ZW'(16384)) begin
			z0 = zr - ZW'(32768);
		end else if (zr < -ZW'(16384)) begin
			z0 = zr + ZW'(32768);
		end else begin
			z0 = zr;
		end
		x0 = XW'(vx_in) <<< cwsm_pkg::GUARD_SHIFT;
		y0 = XW'(vy_in) <<< cwsm_pkg::GUARD_SHIFT;
		if (fold) begin
			x0 = -x0;
			y0 = -y0;
		end
	end

	logic vld_c [0:NS];
	logic signed [XW-1:0] x_c [0:NS];
	logic signed [XW-1:0] y_c [0:NS];
	logic signed [ZW-1:0] z_c [0:NS];
	logic [3:0][cwsm_pkg::RAD_W-1:0] rad_c [0:NS];
	logic [3:0][cwsm_pkg::REM_W-1:0] rem_c [0:NS];
	logic [3:0][cwsm_pkg::ROOT_W-1:0] root_c [0:NS];
	logic signed [SW-1:0] vx_c [0:NS];
	logic signed [SW-1:0] vy_c [0:NS];
	logic signed [SW-1:0] w_c [0:NS];

	logic vld_s1;
	logic signed [XW-1:0] x_s1, y_s1;
	logic signed [ZW-1:0] z_s1;
	logic [3:0][cwsm_pkg::RAD_W-1:0] rad_s1;
	logic signed [SW-1:0] vx_s1, vy_s1, w_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (en) begin
			vld_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x_s1 <= x0;
			y_s1 <= y0;
			z_s1 <= z0;
			rad_s1[0] <= wfrac_q * lfrac_q;
			rad_s1[1] <= wfrac_q * cl;
			rad_s1[2] <= cw * lfrac_q;
			rad_s1[3] <= cw * cl;
			vx_s1 <= vx_in;
			vy_s1 <= vy_in;
			w_s1 <= w_in;
		end
	end

	assign vld_c[0] = vld_s1;
	assign x_c[0] = x_s1;
	assign y_c[0] = y_s1;
	assign z_c[0] = z_s1;
	assign rad_c[0] = rad_s1;
	assign rem_c[0] = '0;
	assign root_c[0] = '0;
	assign vx_c[0] = vx_s1;
	assign vy_c[0] = vy_s1;
	assign w_c[0] = w_s1;

	// stages 2..9
	for (genvar k = 0; k < NS; k++) begin : g_iter
		cwsm_iter_stage #(.SPEED_WIDTH(SW), .STAGE(k)) u_stage (
			.clk(clk), .arst_n(arst_n), .en(en),
			.vld_i(vld_c[k]), .x_i(x_c[k]), .y_i(y_c[k]), .z_i(z_c[k]),
			.rad_i(rad_c[k]), .rem_i(rem_c[k]), .root_i(root_c[k]),
			.vx_i(vx_c[k]), .vy_i(vy_c[k]), .w_i(w_c[k]),
			.vld_s(vld_c[k+1]), .x_s(x_c[k+1]), .y_s(y_c[k+1]), .z_s(z_c[k+1]),
			.rad_s(rad_c[k+1]), .rem_s(rem_c[k+1]), .root_s(root_c[k+1]),
			.vx_s(vx_c[k+1]), .vy_s(vy_c[k+1]), .w_s(w_c[k+1])
		);
	end

	// stage 10: gain and yaw products
	logic vld_s10;
	logic signed [PX_W-1:0] px_s10, py_s10;
	logic signed [YP_W-1:0] yp_s10 [0:3];
	logic signed [SW-1:0] vx_s10, vy_s10, w_s10;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s10 <= 1'b0;
		end else if (en) begin
			vld_s10 <= vld_c[NS];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			px_s10 <= PX_W'(x_c[NS]) * PX_W'(cwsm_pkg::INV_GAIN_Q15);
			py_s10 <= PX_W'(y_c[NS]) * PX_W'(cwsm_pkg::INV_GAIN_Q15);
			for (int l = 0; l < 4; l++) begin
				yp_s10[l] <= YP_W'(w_c[NS]) *
					$signed({1'b0, root_c[NS][l], 1'b0});
			end
			vx_s10 <= vx_c[NS];
			vy_s10 <= vy_c[NS];
			w_s10 <= w_c[NS];
		end
	end

	// stage 11: rounding, rotated or raw select
	logic signed [PX_W-1:0] pxa, pya;
	logic signed [YP_W-1:0] ypa [0:3];
	logic vld_s11;
	logic signed [VW-1:0] vx_s11, vy_s11, yaw_s11 [0:3];
	logic signed [SW-1:0] w_s11;

	always_comb begin
		pxa = px_s10 + HALF_PX - $signed({{(PX_W-1){1'b0}}, px_s10[PX_W-1]});
		pya = py_s10 + HALF_PX - $signed({{(PX_W-1){1'b0}}, py_s10[PX_W-1]});
		for (int l = 0; l < 4; l++) begin
			ypa[l] = yp_s10[l] + HALF_YP -
				$signed({{(YP_W-1){1'b0}}, yp_s10[l][YP_W-1]});
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s11 <= 1'b0;
		end else if (en) begin
			vld_s11 <= vld_s10;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			vx_s11 <= rot_en ? VW'(pxa >>> 23) : VW'(vx_s10);
			vy_s11 <= rot_en ? VW'(pya >>> 23) : VW'(vy_s10);
			for (int l = 0; l < 4; l++) begin
				yaw_s11[l] <= VW'(ypa[l] >>> 15);
			end
			w_s11 <= w_s10;
		end
	end

	// stage 12: omni cross term
	logic vld_s12;
	logic signed [OM_W-1:0] om_s12;
	logic signed [VW-1:0] vx_s12, vy_s12, yaw_s12 [0:3];
	logic signed [SW-1:0] w_s12;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s12 <= 1'b0;
		end else if (en) begin
			vld_s12 <= vld_s11;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			om_s12 <= OM_W'(vx_s11) * OM_W'(cwsm_pkg::SQRT3_HALF_Q15);
			vx_s12 <= vx_s11;
			vy_s12 <= vy_s11;
			yaw_s12 <= yaw_s11;
			w_s12 <= w_s11;
		end
	end

	// stage 13: mix and saturate into the output register
	logic signed [MW-1:0] mx, my, mw, o1, o2, o1r, o2r;
	logic signed [MW-1:0] wh [0:3];
	logic signed [VW-1:0] sat [0:3];
	logic cmd_ok;

	always_comb begin
		mx = MW'(vx_s12);
		my = MW'(vy_s12);
		mw = MW'(w_s12);
		o1 = MW'(om_s12) - (my <<< 14) + (mw <<< 15);
		o2 = -MW'(om_s12) + (my <<< 14) + (mw <<< 15);
		o1r = (o1 + HALF_M - $signed({{(MW-1){1'b0}}, o1[MW-1]})) >>> 15;
		o2r = (o2 + HALF_M - $signed({{(MW-1){1'b0}}, o2[MW-1]})) >>> 15;
		cmd_ok = 1'b1;
		for (int l = 0; l < 4; l++) begin
			wh[l] = '0;
		end
		case (drive_kind_q)
			cwsm_pkg::DRIVE_DIFF: begin
				wh[0] = mw - mx;
				wh[1] = mx + mw;
			end
			cwsm_pkg::DRIVE_OMNI3: begin
				wh[0] = my + mw;
				wh[1] = o1r;
				wh[2] = o2r;
			end
			cwsm_pkg::DRIVE_SKID: begin
				wh[0] = mw - mx;
				wh[1] = mw - mx;
				wh[2] = mx + mw;
				wh[3] = mx + mw;
			end
			cwsm_pkg::DRIVE_MECANUM: begin
				wh[0] = my + mx + mw;
				wh[1] = -my + mx + mw;
				wh[2] = my - mx + mw;
				wh[3] = -my - mx + mw;
			end
			cwsm_pkg::DRIVE_OFFSET: begin
				if (wfrac_q > FW'(32768) || lfrac_q > FW'(32768)) begin
					cmd_ok = 1'b0;
				end else begin
					wh[0] = my + mx + MW'(yaw_s12[0]);
					wh[1] = -my + mx + MW'(yaw_s12[1]);
					wh[2] = my - mx + MW'(yaw_s12[2]);
					wh[3] = -my - mx + MW'(yaw_s12[3]);
				end
			end
			default: cmd_ok = 1'b0;
		endcase
		for (int l = 0; l < 4; l++) begin
			if (wh[l] > SAT_HI) begin
				sat[l] = VW'(SAT_HI);
			end else if (wh[l] < SAT_LO) begin
				sat[l] = VW'(SAT_LO);
			end else begin
				sat[l] = VW'(wh[l]);
			end
		end
	end

	logic vld_s13;
	logic [OUT_DW-1:0] data_s13;
	logic ok_s13;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s13 <= 1'b0;
		end else if (en) begin
			vld_s13 <= vld_s12;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			data_s13 <= OUT_DW'({sat[3], sat[2], sat[1], sat[0]});
			ok_s13 <= cmd_ok;
		end
	end

	assign m_tvalid = vld_s13;
	assign m_tdata = data_s13;
	assign m_tuser = ok_s13;

endmodule

[sv/cwsm_iter_stage.sv]
// One iteration stage: up to two CORDIC rotation steps for the headless turn and
// two digits of four square roots. Uses cwsm_pkg.
module cwsm_iter_stage #(
	parameter int SPEED_WIDTH = cwsm_pkg::SPEED_WIDTH_DEF,
	parameter int STAGE = 0
) (
	input  logic clk,
	input  logic arst_n,
	input  logic en,
	input  logic vld_i,
	input  logic signed [SPEED_WIDTH+9:0] x_i,
	input  logic signed [SPEED_WIDTH+9:0] y_i,
	input  logic signed [cwsm_pkg::ZW-1:0] z_i,
	input  logic [3:0][cwsm_pkg::RAD_W-1:0] rad_i,
	input  logic [3:0][cwsm_pkg::REM_W-1:0] rem_i,
	input  logic [3:0][cwsm_pkg::ROOT_W-1:0] root_i,
	input  logic signed [SPEED_WIDTH-1:0] vx_i,
	input  logic signed [SPEED_WIDTH-1:0] vy_i,
	input  logic signed [SPEED_WIDTH-1:0] w_i,
	output logic vld_s,
	output logic signed [SPEED_WIDTH+9:0] x_s,
	output logic signed [SPEED_WIDTH+9:0] y_s,
	output logic signed [cwsm_pkg::ZW-1:0] z_s,
	output logic [3:0][cwsm_pkg::RAD_W-1:0] rad_s,
	output logic [3:0][cwsm_pkg::REM_W-1:0] rem_s,
	output logic [3:0][cwsm_pkg::ROOT_W-1:0] root_s,
	output logic signed [SPEED_WIDTH-1:0] vx_s,
	output logic signed [SPEED_WIDTH-1:0] vy_s,
	output logic signed [SPEED_WIDTH-1:0] w_s
);
	localparam int XW = SPEED_WIDTH + 10;

	logic signed [XW-1:0] x_n, y_n;
	logic signed [cwsm_pkg::ZW-1:0] z_n;
	logic [3:0][cwsm_pkg::RAD_W-1:0] rad_n;
	logic [3:0][cwsm_pkg::REM_W-1:0] rem_n;
	logic [3:0][cwsm_pkg::ROOT_W-1:0] root_n;

	always_comb begin
		logic signed [XW-1:0] dx, dy;
		logic [cwsm_pkg::REM_W-1:0] trial;
		x_n = x_i;
		y_n = y_i;
		z_n = z_i;
		for (int j = 0; j < 2; j++) begin
			if (2*STAGE + j < cwsm_pkg::CORDIC_STEPS) begin
				dx = y_n >>> (2*STAGE + j);
				dy = x_n >>> (2*STAGE + j);
				if (!z_n[cwsm_pkg::ZW-1]) begin
					x_n = x_n - dx;
					y_n = y_n + dy;
					z_n = z_n - cwsm_pkg::atan_turn(2*STAGE + j);
				end else begin
					x_n = x_n + dx;
					y_n = y_n - dy;
					z_n = z_n + cwsm_pkg::atan_turn(2*STAGE + j);
				end
			end
		end
		rad_n = rad_i;
		rem_n = rem_i;
		root_n = root_i;
		for (int l = 0; l < 4; l++) begin
			for (int j = 0; j < 2; j++) begin
				rem_n[l] = {rem_n[l][cwsm_pkg::REM_W-3:0],
					rad_n[l][cwsm_pkg::RAD_W-1 -: 2]};
				rad_n[l] = rad_n[l] << 2;
				trial = cwsm_pkg::REM_W'({root_n[l], 2'b01});
				if (rem_n[l] >= trial) begin
					rem_n[l] = rem_n[l] - trial;
					root_n[l] = {root_n[l][cwsm_pkg::ROOT_W-2:0], 1'b1};
				end else begin
					root_n[l] = {root_n[l][cwsm_pkg::ROOT_W-2:0], 1'b0};
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= 1'b0;
		end else if (en) begin
			vld_s <= vld_i;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x_s <= x_n;
			y_s <= y_n;
			z_s <= z_n;
			rad_s <= rad_n;
			rem_s <= rem_n;
			root_s <= root_n;
			vx_s <= vx_i;
			vy_s <= vy_i;
			w_s <= w_i;
		end
	end

endmodule

[sv/cwsm_checker.sv]
// Port-level checks for the wheel speed mixer, bound to the top level.
// Uses chassis_wheel_speed_mixer_unit_defines.svh.
`include "chassis_wheel_speed_mixer_unit_defines.svh"

module cwsm_checker #(
	parameter int SPEED_WIDTH = cwsm_pkg::SPEED_WIDTH_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic s_tready,
	input logic m_tvalid,
	input logic m_tready,
	input logic [((4*(SPEED_WIDTH+2)+7)/8)*8-1:0] m_tdata,
	input logic [0:0] m_tuser
);

	// an invalid command carries all-zero wheels
	`CWSM_ASSERT_IMP(a_invalid_zero, m_tvalid && !m_tuser[0], m_tdata == '0)
	// input side is open whenever the output register is free
	`CWSM_ASSERT_IMP(a_ready_when_free, !m_tvalid || m_tready, s_tready)
	// held result stays put
	`CWSM_ASSERT_NXT(a_hold_valid, m_tvalid && !m_tready, m_tvalid)
	`CWSM_ASSERT_NXT(a_hold_data, m_tvalid && !m_tready,
		$stable(m_tdata) && $stable(m_tuser))

endmodule

bind chassis_wheel_speed_mixer_unit cwsm_checker #(.SPEED_WIDTH(SPEED_WIDTH)) u_cwsm_checker (
	.clk(clk), .arst_n(arst_n), .s_tready(s_tready), .m_tvalid(m_tvalid),
	.m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
);
